/* hw/rtl/fqr_pkg.sv */
// ----------------------------------------------------------------------------
// fqr_pkg
// Shared types and constants for the FIFO queue with remove-by-id block.
// ----------------------------------------------------------------------------
package fqr_pkg;

    localparam int DEPTH   = 16;
    localparam int ID_BITS = 16;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int IDX_W   = $clog2(DEPTH);

    localparam int ACTION_W = 2;
    localparam int PID_W    = 16;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 24;   // action + process_id, padded to bytes
    localparam int M_DATA_W = 24;   // status + id_out + now_empty, padded

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DEQUEUE = 2'd1,
        ACT_REMOVE  = 2'd2
    } action_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK        = 2'd0,
        STS_EMPTY     = 2'd1,
        STS_NOT_FOUND = 2'd2,
        STS_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        CTRL_IDLE,
        CTRL_EXEC
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;   // latch the accepted input item
        logic execute;   // apply the action and load the result register
    } dp_cmd_t;

endpackage

/* hw/rtl/fqr_ctrl.sv */
// ----------------------------------------------------------------------------
// fqr_ctrl
// Handshake controller: accepts an item, schedules its execution and owns
// the valid flag of the result register.
// ----------------------------------------------------------------------------
module fqr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output fqr_pkg::dp_cmd_t cmd
);
    import fqr_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        out_free;

    // The result register can take a new result when empty or being drained.
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            CTRL_IDLE: begin
                if (s_tvalid) begin
                    state_next = CTRL_EXEC;
                end
            end
            CTRL_EXEC: begin
                if (out_free) begin
                    state_next = CTRL_IDLE;
                end
            end
            default: state_next = CTRL_IDLE;
        endcase
    end

    always_comb begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            CTRL_IDLE: begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            CTRL_EXEC: begin
                cmd.execute = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        out_valid_next = out_valid_reg;
        if (cmd.execute) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= CTRL_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

/* hw/rtl/fqr_datapath.sv */
// ----------------------------------------------------------------------------
// fqr_datapath
// Shift-register queue: parallel match, gap-closing shift and the result
// register.
// ----------------------------------------------------------------------------
module fqr_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  fqr_pkg::dp_cmd_t              cmd,
    input  logic [fqr_pkg::ACTION_W-1:0]  in_action,
    input  logic [fqr_pkg::PID_W-1:0]     in_pid,
    output logic [fqr_pkg::STATUS_W-1:0]  out_status,
    output logic [fqr_pkg::PID_W-1:0]     out_id,
    output logic                          out_now_empty
);
    import fqr_pkg::*;

    logic [ACTION_W-1:0] action_reg;
    logic [ID_BITS-1:0]  pid_reg;

    logic [ID_BITS-1:0]  entry_reg  [DEPTH];
    logic [ID_BITS-1:0]  entry_next [DEPTH];
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [DEPTH-1:0]    match;
    logic [DEPTH-1:0]    shift_from;   // slot takes its right neighbor
    logic                found;
    logic                write_tail;

    logic [STATUS_W-1:0] status_reg, status_next;
    logic [PID_W-1:0]    id_reg, id_next;
    logic                empty_reg;

    // Compare every occupied slot against the requested id.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            match[i] = (CNT_W'(i) < count_reg) && (entry_reg[i] == pid_reg);
        end
    end

    assign found = |match;

    always_comb begin
        count_next  = count_reg;
        status_next = STS_OK;
        id_next     = '0;
        shift_from  = '0;
        write_tail  = 1'b0;
        case (action_reg)
            ACT_ENQUEUE: begin
                if (count_reg >= CNT_W'(DEPTH)) begin
                    status_next = STS_FULL;
                end else begin
                    write_tail = 1'b1;
                    count_next = count_reg + 1'b1;
                end
            end
            ACT_DEQUEUE: begin
                if (count_reg == '0) begin
                    status_next = STS_EMPTY;
                end else begin
                    id_next    = PID_W'(entry_reg[0]);
                    shift_from = '1;
                    count_next = count_reg - 1'b1;
                end
            end
            ACT_REMOVE: begin
                if (!found) begin
                    status_next = STS_NOT_FOUND;
                end else begin
                    // Shift every slot at or after the first match.
                    shift_from[0] = match[0];
                    for (int i = 1; i < DEPTH; i++) begin
                        shift_from[i] = shift_from[i-1] | match[i];
                    end
                    count_next = count_reg - 1'b1;
                end
            end
            default: begin
                status_next = STS_OK;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            entry_next[i] = entry_reg[i];
            if (shift_from[i] && (i + 1 < DEPTH)) begin
                entry_next[i] = entry_reg[(i + 1) % DEPTH];
            end
            if (write_tail && (count_reg[IDX_W-1:0] == IDX_W'(i))) begin
                entry_next[i] = pid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            action_reg <= in_action;
            pid_reg    <= in_pid[ID_BITS-1:0];
        end
        if (cmd.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                entry_reg[i] <= entry_next[i];
            end
            status_reg <= status_next;
            id_reg     <= id_next;
            empty_reg  <= (count_next == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.execute) begin
            count_reg <= count_next;
        end
    end

    assign out_status    = status_reg;
    assign out_id        = id_reg;
    assign out_now_empty = empty_reg;

endmodule

/* hw/rtl/fifo_queue_with_remove_by_id_core.sv */
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_core
// Bounded FIFO of process ids with enqueue, dequeue and remove-by-id.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries one request per transfer: an action (enqueue,
//   dequeue or remove by id) and a process id. The master stream returns one
//   result per request: a status code, the dequeued id (zero unless a
//   dequeue succeeded) and a flag telling whether the queue is empty after
//   the action. Results come back in request order.
//   A request is captured when it is accepted and executed once the result
//   register is free; its result is then presented on the master side.
//   A new request is not accepted before the previous one has executed, as
//   set by the capture/execute sequence of the controller; the match over
//   all DEPTH slots and the gap-closing shift are applied in the execute step.
//   A new request is accepted while the previous result still waits in the
//   output register; if the receiver stalls, the controller holds in its
//   execute state until that register is drained, and s_tready stays low.
//   Reset (aresetn low, synchronous) empties the queue and drops any
//   pending result; slot contents are not cleared and are never read
//   before they are written.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [fqr_pkg::S_DATA_W-1:0]   s_tdata,   // [1:0] action, [17:2] process_id
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [fqr_pkg::M_DATA_W-1:0]   m_tdata    // [1:0] status, [17:2] id_out,
                                                      // [18] now_empty
);
    import fqr_pkg::*;

    dp_cmd_t             cmd;
    logic [STATUS_W-1:0] res_status;
    logic [PID_W-1:0]    res_id;
    logic                res_empty;

    // Sequence each transfer: capture, then execute once the output is free.
    fqr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Queue storage, match/shift logic and result register.
    fqr_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .in_action     (s_tdata[ACTION_W-1:0]),
        .in_pid        (s_tdata[ACTION_W+PID_W-1:ACTION_W]),
        .out_status    (res_status),
        .out_id        (res_id),
        .out_now_empty (res_empty)
    );

    // Pack result fields from the lowest bit up, pad to whole bytes.
    assign m_tdata = {{(M_DATA_W - STATUS_W - PID_W - 1){1'b0}},
                      res_empty, res_id, res_status};

endmodule

/* tb/sv/fifo_queue_with_remove_by_id_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_queue_with_remove_by_id_core_tb
// Self-checking bench for the process-id FIFO with remove-by-id.
// A request queue is filled up front: a directed opening covers empty, full,
// tail removal, duplicates and the unused action code. About 500 random
// requests follow, in phases that lean toward filling, draining or neither
// and draw ids from a small pool so that removals find their target. A shadow
// queue predicts every result. The monitor compares each result field by
// field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module fifo_queue_with_remove_by_id_core_tb;
    import fqr_pkg::*;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;   // no-op code, no enum member
    localparam int  MAX_IDLE    = 13;
    localparam int  RANDOM_REQS = 500;
    localparam int  DRAIN_CYCLES = 10;
    localparam int  STALL_LIMIT = 2000;

    typedef struct {
        logic [ACTION_W-1:0] action;
        logic [PID_W-1:0]    pid;
        int unsigned         gap;      // idle cycles before this transfer
    } request_t;

    typedef struct {
        status_t          status;
        logic [PID_W-1:0] id_out;
        logic             now_empty;
    } result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata  = '0;   // [1:0] action, [17:2] process_id
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;         // [1:0] status, [17:2] id_out, [18] now_empty

    request_t              pending_requests[$];
    result_t               predicted_results[$];
    logic [ID_BITS-1:0]    shadow_ids[$];   // head at index 0
    int unsigned           error_count = 0;
    int unsigned           stall_cycles = 0;
    bit                    tx_calm = 1'b0;
    bit                    rx_calm = 1'b0;

    // driver-side holding of the next request while its gap runs out
    request_t              next_req;
    bit                    req_staged = 1'b0;
    int unsigned           tx_wait = 0;
    int unsigned           rx_wait = 0;

    fifo_queue_with_remove_by_id_core u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Apply one action to the shadow queue and record the result it must give.
    function automatic void queue_action_outcome(input logic [ACTION_W-1:0] action,
                                                 input logic [PID_W-1:0] pid);
        result_t            res;
        logic [ID_BITS-1:0] key;
        int                 hit;
        res.status = STS_OK;
        res.id_out = '0;
        key = pid[ID_BITS-1:0];
        case (action)
            ACT_ENQUEUE: begin
                if (shadow_ids.size() >= DEPTH)
                    res.status = STS_FULL;
                else
                    shadow_ids.push_back(key);
            end
            ACT_DEQUEUE: begin
                if (shadow_ids.size() == 0)
                    res.status = STS_EMPTY;
                else
                    res.id_out = PID_W'(shadow_ids.pop_front());
            end
            ACT_REMOVE: begin
                // first match counted from the head; later duplicates stay
                hit = -1;
                for (int i = 0; i < shadow_ids.size(); i++) begin
                    if (hit < 0 && shadow_ids[i] == key)
                        hit = i;
                end
                if (hit < 0)
                    res.status = STS_NOT_FOUND;
                else
                    shadow_ids.delete(hit);
            end
            default: ;   // unused code leaves the queue alone
        endcase
        res.now_empty = (shadow_ids.size() == 0);
        predicted_results.push_back(res);
    endfunction

    function automatic int unsigned draw_idle(input bit calm);
        return calm ? 0 : $urandom_range(0, MAX_IDLE);
    endfunction

    task automatic add_request(input logic [ACTION_W-1:0] action,
                               input logic [PID_W-1:0] pid);
        request_t req;
        req.action = action;
        req.pid    = pid;
        req.gap    = draw_idle(tx_calm);
        pending_requests.push_back(req);
    endtask

    task automatic compare_field(input string name, input int unsigned want,
                                 input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: pop the next request, hold tvalid low for its gap,
    // then present it until accepted. Predict at presentation time; order
    // is fixed, so the shadow state matches acceptance order.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid   <= 1'b0;
            s_tdata    <= '0;
            req_staged = 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (!req_staged && pending_requests.size() > 0) begin
                next_req   = pending_requests.pop_front();
                tx_wait    = next_req.gap;
                req_staged = 1'b1;
            end
            if (req_staged && tx_wait == 0) begin
                s_tvalid <= 1'b1;
                s_tdata  <= {{(S_DATA_W - ACTION_W - PID_W){1'b0}}, next_req.pid,
                             next_req.action};
                queue_action_outcome(next_req.action, next_req.pid);
                req_staged = 1'b0;
            end else begin
                s_tvalid <= 1'b0;
                if (req_staged)
                    tx_wait--;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: check each transfer against the oldest prediction,
    // then stall tready for a random count. Calm stretches drop the stalls.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_wait  = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (predicted_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual 0x%0h",
                             $time, m_tdata);
                    error_count++;
                end else begin
                    want = predicted_results.pop_front();
                    compare_field("status", want.status, m_tdata[1:0]);
                    compare_field("id_out", want.id_out, m_tdata[17:2]);
                    compare_field("now_empty", want.now_empty, m_tdata[18]);
                end
                if ($urandom_range(0, 31) == 0)
                    rx_calm = !rx_calm;
                rx_wait = draw_idle(rx_calm);
            end
            if (rx_wait > 0) begin
                rx_wait--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Watchdog: end the run if neither side moves a transfer for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: timeout, no transfer for %0d cycles", $time, STALL_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial begin
        logic [PID_W-1:0]    id_pool[4];
        logic [ACTION_W-1:0] act;
        logic [PID_W-1:0]    pid;
        int unsigned         lean;
        int unsigned         roll;

        // Directed opening: empty-queue cases first.
        add_request(ACT_DEQUEUE, 16'h1234);
        add_request(ACT_REMOVE,  16'h1234);
        add_request(ACT_UNUSED,  16'hFFFF);
        // Remove the only entry, which is also the tail.
        add_request(ACT_ENQUEUE, 16'hFFFF);
        add_request(ACT_REMOVE,  16'hFFFF);
        // Fill to DEPTH with extremes and duplicates of 0xAAAA.
        add_request(ACT_ENQUEUE, 16'h0000);
        add_request(ACT_ENQUEUE, 16'hFFFF);
        for (int i = 0; i < DEPTH - 2; i++)
            add_request(ACT_ENQUEUE, (i % 3 == 0) ? 16'hAAAA : 16'h5555 ^ PID_W'(i));
        add_request(ACT_ENQUEUE, 16'h7E7E);   // full
        add_request(ACT_REMOVE,  16'h5555 ^ PID_W'(DEPTH - 3));   // tail entry
        add_request(ACT_REMOVE,  16'hAAAA);   // nearest duplicate to the head
        add_request(ACT_DEQUEUE, 16'h0000);
        add_request(ACT_REMOVE,  16'hBEEF);   // not present
        add_request(ACT_UNUSED,  16'h0000);

        // Random phases: each leans toward filling, draining or neither.
        for (int n = 0; n < RANDOM_REQS; n++) begin
            if (n % 40 == 0) begin
                lean    = $urandom_range(0, 2);
                tx_calm = ($urandom_range(0, 3) == 0);
                foreach (id_pool[k])
                    id_pool[k] = PID_W'($urandom);
            end
            roll = $urandom_range(0, 99);
            if (roll < 3)
                act = ACT_UNUSED;
            else if (roll < (lean == 0 ? 70 : lean == 1 ? 25 : 45))
                act = ACT_ENQUEUE;
            else if (roll < (lean == 0 ? 85 : lean == 1 ? 60 : 70))
                act = ACT_DEQUEUE;
            else
                act = ACT_REMOVE;
            pid = ($urandom_range(0, 99) < 85) ? id_pool[$urandom_range(0, 3)]
                                               : PID_W'($urandom);
            add_request(act, pid);
        end

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Hold until every request is out and every result is back.
        while (pending_requests.size() > 0 || req_staged || s_tvalid ||
               predicted_results.size() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/fqr_pkg.sv
hw/rtl/fqr_ctrl.sv
hw/rtl/fqr_datapath.sv
hw/rtl/fifo_queue_with_remove_by_id_core.sv
tb/sv/fifo_queue_with_remove_by_id_core_tb.sv
